### sv/lali_pkg.sv
// Package for the link-aware LED indicator: operation, mode and power codes,
// configuration register indexes and reset values, and the shared structs.
// No dependencies.
package lali_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BEAT = 2'd1;
    localparam logic [1:0] OP_SYNC = 2'd2;
    localparam logic [1:0] OP_LED  = 2'd3;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;
    localparam logic [1:0] MODE_FADE  = 2'd3;

    localparam logic [1:0] PWR_ACTIVE  = 2'd0;
    localparam logic [1:0] PWR_LOW     = 2'd1;
    localparam logic [1:0] PWR_MINIMAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_INC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLINK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_BLINK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PHASE   = 3'd6;

    localparam logic [2:0]  OWN_NODE_RST     = 3'd1;
    localparam logic [15:0] LINK_TIMEOUT_RST = 16'd3000;
    localparam logic [7:0]  FADE_INC_RST     = 8'd5;
    localparam logic [9:0]  FADE_PERIOD_RST  = 10'd20;
    localparam logic [15:0] SLOW_BLINK_RST   = 16'd500;
    localparam logic [15:0] FAST_BLINK_RST   = 16'd100;
    localparam logic [15:0] FAST_PHASE_RST   = 16'd3000;

    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam logic [2:0] NODE_MIN  = 3'd1;
    localparam logic [2:0] NODE_MAX  = 3'd4;

    typedef struct packed {
        logic [2:0]  own_node;
        logic [15:0] link_timeout_ms;
        logic [7:0]  fade_increment;
        logic [9:0]  fade_period_ms;
        logic [15:0] slow_blink_ms;
        logic [15:0] fast_blink_ms;
        logic [15:0] fast_phase_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] msg_node;
        logic [7:0] sync_word;
        logic [1:0] led_mode_cmd;
    } item_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [1:0] power_mode;
        logic       link_up;
        logic       request_state;
        logic [1:0] led_mode;
    } res_t;

endpackage

### sv/lali_item_if.sv
// Input item channel of the LED indicator: valid/ready handshake and payload.
// No dependencies.
interface lali_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] msg_node;
    logic [7:0] sync_word;
    logic [1:0] led_mode_cmd;

    modport source (output valid, output operation, output msg_node, output sync_word,
                    output led_mode_cmd, input ready);
    modport sink (input valid, input operation, input msg_node, input sync_word,
                  input led_mode_cmd, output ready);
endinterface

### sv/lali_result_if.sv
// Result item channel of the LED indicator: valid/ready handshake and payload.
// No dependencies.
interface lali_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] brightness;
    logic [1:0] power_mode;
    logic       link_up;
    logic       request_state;
    logic [1:0] led_mode;

    modport source (output valid, output brightness, output power_mode, output link_up,
                    output request_state, output led_mode, input ready);
    modport sink (input valid, input brightness, input power_mode, input link_up,
                  input request_state, input led_mode, output ready);
endinterface

### sv/lali_core.sv
// LED indicator state: millisecond clock, link state, LED mode and timers.
// Computes the next state and the result of one item. Depends on lali_pkg.
module lali_core #(
    parameter int TIME_BITS = lali_pkg::TIME_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  lali_pkg::item_t item,
    input  lali_pkg::cfg_t  cfg,
    output lali_pkg::res_t  res
);
    import lali_pkg::*;

    logic [TIME_BITS-1:0] clock_ms_reg, clock_ms_next;
    logic [TIME_BITS-1:0] last_beat_ms_reg, last_beat_ms_next;
    logic [TIME_BITS-1:0] last_toggle_ms_reg, last_toggle_ms_next;
    logic [TIME_BITS-1:0] fast_start_ms_reg, fast_start_ms_next;
    logic [TIME_BITS-1:0] last_fade_ms_reg, last_fade_ms_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] level_reg, level_next;
    logic [7:0] pwm_reg, pwm_next;
    logic [1:0] power_reg, power_next;
    logic fading_up_reg, fading_up_next;
    logic blink_lit_reg, blink_lit_next;
    logic in_fast_phase_reg, in_fast_phase_next;
    logic connected_reg, connected_next;

    logic [TIME_BITS-1:0] clk_inc;
    logic [TIME_BITS-1:0] beat_el;
    logic [TIME_BITS-1:0] fade_el;
    logic [TIME_BITS-1:0] fast_el;
    logic [TIME_BITS-1:0] toggle_el;
    logic [TIME_BITS-1:0] interval;
    logic       timeout;
    logic       fade_due;
    logic [1:0] mode_eff;
    logic [7:0] level_eff;
    logic       fading_eff;
    logic [8:0] level_sum;
    logic [7:0] fade_v;
    logic       request;
    logic       own_msg;
    logic       locked;
    logic [2:0] sel;

    assign clk_inc   = clock_ms_reg + 1'b1;
    assign beat_el   = clk_inc - last_beat_ms_reg;
    assign fade_el   = clk_inc - last_fade_ms_reg;
    assign fast_el   = clk_inc - fast_start_ms_reg;
    assign toggle_el = clk_inc - last_toggle_ms_reg;
    assign timeout   = connected_reg && (beat_el > TIME_BITS'(cfg.link_timeout_ms));
    assign own_msg   = item.msg_node == {5'd0, cfg.own_node};
    assign sel       = item.sync_word[6:4];
    assign locked    = (cfg.own_node inside {[NODE_MIN:NODE_MAX]}) &&
                       item.sync_word[2'(cfg.own_node - NODE_MIN)];

    always_comb
    begin
        clock_ms_next       = clock_ms_reg;
        last_beat_ms_next   = last_beat_ms_reg;
        last_toggle_ms_next = last_toggle_ms_reg;
        fast_start_ms_next  = fast_start_ms_reg;
        last_fade_ms_next   = last_fade_ms_reg;
        mode_next           = mode_reg;
        level_next          = level_reg;
        pwm_next            = pwm_reg;
        power_next          = power_reg;
        fading_up_next      = fading_up_reg;
        blink_lit_next      = blink_lit_reg;
        in_fast_phase_next  = in_fast_phase_reg;
        connected_next      = connected_reg;
        request             = 1'b0;
        interval            = TIME_BITS'(cfg.slow_blink_ms);

        mode_eff   = timeout ? MODE_FADE : mode_reg;
        level_eff  = timeout ? 8'd0 : level_reg;
        fading_eff = timeout ? 1'b1 : fading_up_reg;
        fade_due   = timeout ? (cfg.fade_period_ms == 10'd0)
                             : (fade_el >= TIME_BITS'(cfg.fade_period_ms));
        level_sum  = {1'b0, level_eff} + {1'b0, cfg.fade_increment};
        if (fading_eff)
        begin
            fade_v = level_sum[8] ? LEVEL_MAX : level_sum[7:0];
        end
        else
        begin
            fade_v = (level_eff > cfg.fade_increment) ? level_eff - cfg.fade_increment : 8'd0;
        end

        case (item.operation)
            OP_TICK:
            begin
                clock_ms_next = clk_inc;
                if (timeout)
                begin
                    connected_next    = 1'b0;
                    mode_next         = MODE_FADE;
                    level_next        = 8'd0;
                    fading_up_next    = 1'b1;
                    last_fade_ms_next = clk_inc;
                    power_next        = PWR_MINIMAL;
                end
                case (mode_eff)
                    MODE_ON:
                    begin
                        pwm_next = LEVEL_MAX;
                    end
                    MODE_OFF:
                    begin
                        pwm_next = 8'd0;
                    end
                    MODE_FADE:
                    begin
                        if (fade_due)
                        begin
                            last_fade_ms_next = clk_inc;
                            level_next        = fade_v;
                            pwm_next          = fade_v;
                            if (fade_v == 8'd0)
                            begin
                                fading_up_next = 1'b1;
                            end
                            else if (fade_v == LEVEL_MAX)
                            begin
                                fading_up_next = 1'b0;
                            end
                            else
                            begin
                                fading_up_next = fading_eff;
                            end
                        end
                    end
                    default:
                    begin
                        if (in_fast_phase_reg)
                        begin
                            if (fast_el >= TIME_BITS'(cfg.fast_phase_ms))
                            begin
                                in_fast_phase_next = 1'b0;
                            end
                            else
                            begin
                                interval = TIME_BITS'(cfg.fast_blink_ms);
                            end
                        end
                        if (toggle_el >= interval)
                        begin
                            blink_lit_next      = !blink_lit_reg;
                            pwm_next            = blink_lit_reg ? 8'd0 : LEVEL_MAX;
                            last_toggle_ms_next = clk_inc;
                        end
                    end
                endcase
            end
            OP_BEAT:
            begin
                last_beat_ms_next = clock_ms_reg;
                if (!connected_reg)
                begin
                    connected_next = 1'b1;
                    request        = 1'b1;
                end
            end
            OP_SYNC:
            begin
                if (own_msg)
                begin
                    if (sel == cfg.own_node)
                    begin
                        mode_next           = MODE_BLINK;
                        last_toggle_ms_next = clock_ms_reg;
                        in_fast_phase_next  = 1'b1;
                        fast_start_ms_next  = clock_ms_reg;
                        power_next          = PWR_LOW;
                    end
                    else if (sel == 3'd0 || (item.sync_word[7] && !locked))
                    begin
                        mode_next  = MODE_ON;
                        power_next = PWR_ACTIVE;
                    end
                    else
                    begin
                        mode_next  = MODE_OFF;
                        power_next = PWR_LOW;
                    end
                end
            end
            default:
            begin
                if (own_msg)
                begin
                    case (item.led_mode_cmd)
                        MODE_ON:
                        begin
                            mode_next      = MODE_ON;
                            pwm_next       = LEVEL_MAX;
                            blink_lit_next = 1'b1;
                            power_next     = PWR_ACTIVE;
                        end
                        MODE_OFF:
                        begin
                            mode_next      = MODE_OFF;
                            pwm_next       = 8'd0;
                            blink_lit_next = 1'b0;
                            power_next     = PWR_LOW;
                        end
                        MODE_BLINK:
                        begin
                            mode_next           = MODE_BLINK;
                            last_toggle_ms_next = clock_ms_reg;
                            in_fast_phase_next  = 1'b1;
                            fast_start_ms_next  = clock_ms_reg;
                            power_next          = PWR_LOW;
                        end
                        default:
                        begin
                            mode_next         = MODE_FADE;
                            level_next        = 8'd0;
                            fading_up_next    = 1'b1;
                            last_fade_ms_next = clock_ms_reg;
                            power_next        = PWR_MINIMAL;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_ms_reg       <= '0;
            last_beat_ms_reg   <= '0;
            last_toggle_ms_reg <= '0;
            fast_start_ms_reg  <= '0;
            last_fade_ms_reg   <= '0;
            mode_reg           <= MODE_FADE;
            level_reg          <= 8'd0;
            pwm_reg            <= 8'd0;
            power_reg          <= PWR_MINIMAL;
            fading_up_reg      <= 1'b1;
            blink_lit_reg      <= 1'b0;
            in_fast_phase_reg  <= 1'b0;
            connected_reg      <= 1'b0;
        end
        else if (step)
        begin
            clock_ms_reg       <= clock_ms_next;
            last_beat_ms_reg   <= last_beat_ms_next;
            last_toggle_ms_reg <= last_toggle_ms_next;
            fast_start_ms_reg  <= fast_start_ms_next;
            last_fade_ms_reg   <= last_fade_ms_next;
            mode_reg           <= mode_next;
            level_reg          <= level_next;
            pwm_reg            <= pwm_next;
            power_reg          <= power_next;
            fading_up_reg      <= fading_up_next;
            blink_lit_reg      <= blink_lit_next;
            in_fast_phase_reg  <= in_fast_phase_next;
            connected_reg      <= connected_next;
        end
    end

    assign res.brightness    = pwm_next;
    assign res.power_mode    = power_next;
    assign res.link_up       = connected_next;
    assign res.request_state = request;
    assign res.led_mode      = mode_next;

`ifndef SYNTHESIS
    a_request_link: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.request_state |-> res.link_up)
        else $error("state request without link");
    a_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.operation == OP_TICK && mode_reg == MODE_ON && !timeout
        |=> pwm_reg == LEVEL_MAX)
        else $error("on mode tick did not drive full brightness");
    a_timeout_fade: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.operation == OP_TICK && timeout
        |=> mode_reg == MODE_FADE && !connected_reg && power_reg == PWR_MINIMAL)
        else $error("link loss did not enter fade");
`endif

endmodule

### sv/link_aware_led_indicator.sv
// Link-aware LED indicator top level: configuration registers, input item
// register and result register around lali_core. Depends on lali_pkg,
// lali_item_if, lali_result_if and lali_core.
// An accepted item waits in the input item register; its result is held in the result register, which drives valid.
// Throughput: one item per cycle; a waiting result holds the input register and stalls input.
// Reset: asynchronous, clears both stages, loads register defaults, enters fade.
module link_aware_led_indicator #(
    parameter int TIME_BITS = lali_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lali_item_if.sink                      items,
    lali_result_if.source                  results,
    input  logic                           cfg_write,
    input  logic [lali_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lali_pkg::CFG_W-1:0]     cfg_data
);
    import lali_pkg::*;

    cfg_t  cfg_reg;
    item_t item_reg;
    res_t  res_reg;
    res_t  res_next;
    logic  s1_valid_reg;
    logic  out_valid_reg;
    logic  step;

    assign step        = s1_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready = !s1_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_node        <= OWN_NODE_RST;
            cfg_reg.link_timeout_ms <= LINK_TIMEOUT_RST;
            cfg_reg.fade_increment  <= FADE_INC_RST;
            cfg_reg.fade_period_ms  <= FADE_PERIOD_RST;
            cfg_reg.slow_blink_ms   <= SLOW_BLINK_RST;
            cfg_reg.fast_blink_ms   <= FAST_BLINK_RST;
            cfg_reg.fast_phase_ms   <= FAST_PHASE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OWN_NODE:     cfg_reg.own_node        <= cfg_data[2:0];
                CFG_LINK_TIMEOUT: cfg_reg.link_timeout_ms <= cfg_data;
                CFG_FADE_INC:     cfg_reg.fade_increment  <= cfg_data[7:0];
                CFG_FADE_PERIOD:  cfg_reg.fade_period_ms  <= cfg_data[9:0];
                CFG_SLOW_BLINK:   cfg_reg.slow_blink_ms   <= cfg_data;
                CFG_FAST_BLINK:   cfg_reg.fast_blink_ms   <= cfg_data;
                CFG_FAST_PHASE:   cfg_reg.fast_phase_ms   <= cfg_data;
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (items.valid && items.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            item_reg.operation    <= items.operation;
            item_reg.msg_node     <= items.msg_node;
            item_reg.sync_word    <= items.sync_word;
            item_reg.led_mode_cmd <= items.led_mode_cmd;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    lali_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    assign results.valid         = out_valid_reg;
    assign results.brightness    = res_reg.brightness;
    assign results.power_mode    = res_reg.power_mode;
    assign results.link_up       = res_reg.link_up;
    assign results.request_state = res_reg.request_state;
    assign results.led_mode      = res_reg.led_mode;

`ifndef SYNTHESIS
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> s1_valid_reg)
        else $error("accepted item not held");
    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step |=> s1_valid_reg)
        else $error("waiting item dropped");
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result not presented");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |-> !step)
        else $error("pending result overwritten");
`endif

endmodule
